// File: rtl/core/lgv8dec_pkg.sv
// ----------------------------------------------------------------------------
// lgv8dec_pkg: shared types and constants of the LEGv8 decoder
// Mnemonic codes, opcode values, field widths and the decoded-word record.
// ----------------------------------------------------------------------------
package lgv8dec_pkg;

    localparam int unsigned LabelEntriesDef = 64;
    localparam int unsigned WordW           = 32;
    localparam int unsigned LabelW          = 7;
    localparam int unsigned RegW            = 5;
    localparam int unsigned ShW             = 6;
    localparam int unsigned ImmW            = 12;

    typedef enum logic [4:0] {
        MN_ADD   = 5'd0,
        MN_AND   = 5'd1,
        MN_BR    = 5'd2,
        MN_EOR   = 5'd3,
        MN_LSL   = 5'd4,
        MN_LSR   = 5'd5,
        MN_ORR   = 5'd6,
        MN_SUB   = 5'd7,
        MN_SUBS  = 5'd8,
        MN_MUL   = 5'd9,
        MN_PRNT  = 5'd10,
        MN_PRNL  = 5'd11,
        MN_DUMP  = 5'd12,
        MN_HALT  = 5'd13,
        MN_ADDI  = 5'd14,
        MN_ANDI  = 5'd15,
        MN_EORI  = 5'd16,
        MN_ORRI  = 5'd17,
        MN_SUBI  = 5'd18,
        MN_SUBIS = 5'd19,
        MN_LDUR  = 5'd20,
        MN_STUR  = 5'd21,
        MN_B     = 5'd22,
        MN_BL    = 5'd23,
        MN_BCOND = 5'd24,
        MN_CBNZ  = 5'd25,
        MN_CBZ   = 5'd26,
        MN_UNKN  = 5'd27
    } t_mnem;

    localparam logic [10:0] OP_ADD   = 11'h458;
    localparam logic [10:0] OP_AND   = 11'h450;
    localparam logic [10:0] OP_BR    = 11'h6B0;
    localparam logic [10:0] OP_EOR   = 11'h650;
    localparam logic [10:0] OP_LSL   = 11'h69B;
    localparam logic [10:0] OP_LSR   = 11'h69A;
    localparam logic [10:0] OP_ORR   = 11'h550;
    localparam logic [10:0] OP_SUB   = 11'h658;
    localparam logic [10:0] OP_SUBS  = 11'h758;
    localparam logic [10:0] OP_MUL   = 11'h4D8;
    localparam logic [10:0] OP_PRNT  = 11'h7FD;
    localparam logic [10:0] OP_PRNL  = 11'h7FC;
    localparam logic [10:0] OP_DUMP  = 11'h7FE;
    localparam logic [10:0] OP_HALT  = 11'h7FF;
    localparam logic [10:0] OP_LDUR  = 11'h7C2;
    localparam logic [10:0] OP_STUR  = 11'h7C0;

    localparam logic [9:0]  OP_ADDI  = 10'h244;
    localparam logic [9:0]  OP_ANDI  = 10'h248;
    localparam logic [9:0]  OP_EORI  = 10'h348;
    localparam logic [9:0]  OP_ORRI  = 10'h2C8;
    localparam logic [9:0]  OP_SUBI  = 10'h344;
    localparam logic [9:0]  OP_SUBIS = 10'h3C4;

    localparam logic [5:0]  OP_B     = 6'h05;
    localparam logic [5:0]  OP_BL    = 6'h25;

    localparam logic [7:0]  OP_BCOND = 8'h54;
    localparam logic [7:0]  OP_CBNZ  = 8'hB5;
    localparam logic [7:0]  OP_CBZ   = 8'hB4;

    typedef struct packed {
        t_mnem              mnem;
        logic [RegW-1:0]    rd;
        logic [RegW-1:0]    rn;
        logic [RegW-1:0]    rm;
        logic [ShW-1:0]     sh;
        logic [ImmW-1:0]    imm;
        logic [WordW-1:0]   tgt;
        logic               branch;
    } t_dec;

endpackage

// File: rtl/core/lgv8dec_ram.sv
// ----------------------------------------------------------------------------
// lgv8dec_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lgv8dec_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lgv8dec_decode.sv
// ----------------------------------------------------------------------------
// lgv8dec_decode: LEGv8 instruction field decoder
// Classifies the word by R, I, D, B and CB opcode in that order and forms
// register fields, immediate and branch target.
// ----------------------------------------------------------------------------
module lgv8dec_decode
    import lgv8dec_pkg::*;
(
    input  logic [WordW-1:0] i_word,
    input  logic [WordW-1:0] i_pc,
    output t_dec             o_dec
);

    logic [10:0]     w_op11;
    logic [9:0]      w_op10;
    logic [5:0]      w_op6;
    logic [7:0]      w_op8;
    logic [ImmW-1:0] w_imm12;
    logic [ImmW:0]   w_sext;
    logic [ImmW:0]   w_mag;
    logic [ImmW:0]   w_quot;
    logic [ImmW:0]   w_dimm;
    logic [WordW-1:0] w_boff;
    logic [WordW-1:0] w_cboff;

    assign w_op11  = i_word[31:21];
    assign w_op10  = i_word[31:22];
    assign w_op6   = i_word[31:26];
    assign w_op8   = i_word[31:24];
    assign w_imm12 = i_word[21:10];
    assign w_sext  = {w_imm12[ImmW-1], w_imm12};
    assign w_mag   = w_sext[ImmW] ? (~w_sext + 1'b1) : w_sext;
    assign w_quot  = w_mag >> 2;
    assign w_dimm  = w_sext[ImmW] ? (~w_quot + 1'b1) : w_quot;
    assign w_boff  = {{4{i_word[25]}}, i_word[25:0], 2'b00};
    assign w_cboff = {{11{i_word[23]}}, i_word[23:5], 2'b00};

    always_comb begin
        o_dec        = '0;
        o_dec.mnem   = MN_UNKN;
        priority if (w_op11 == OP_ADD || w_op11 == OP_AND || w_op11 == OP_EOR
                     || w_op11 == OP_ORR || w_op11 == OP_SUB || w_op11 == OP_SUBS
                     || w_op11 == OP_MUL) begin
            unique case (w_op11)
                OP_ADD:  o_dec.mnem = MN_ADD;
                OP_AND:  o_dec.mnem = MN_AND;
                OP_EOR:  o_dec.mnem = MN_EOR;
                OP_ORR:  o_dec.mnem = MN_ORR;
                OP_SUB:  o_dec.mnem = MN_SUB;
                OP_SUBS: o_dec.mnem = MN_SUBS;
                default: o_dec.mnem = MN_MUL;
            endcase
            o_dec.rd = i_word[4:0];
            o_dec.rn = i_word[9:5];
            o_dec.rm = i_word[20:16];
        end else if (w_op11 == OP_BR) begin
            o_dec.mnem = MN_BR;
            o_dec.rn   = i_word[9:5];
        end else if (w_op11 == OP_LSL || w_op11 == OP_LSR) begin
            o_dec.mnem = (w_op11 == OP_LSL) ? MN_LSL : MN_LSR;
            o_dec.rd   = i_word[4:0];
            o_dec.rn   = i_word[9:5];
            o_dec.sh   = i_word[15:10];
        end else if (w_op11 == OP_PRNT) begin
            o_dec.mnem = MN_PRNT;
            o_dec.rd   = i_word[4:0];
        end else if (w_op11 == OP_PRNL) begin
            o_dec.mnem = MN_PRNL;
        end else if (w_op11 == OP_DUMP) begin
            o_dec.mnem = MN_DUMP;
        end else if (w_op11 == OP_HALT) begin
            o_dec.mnem = MN_HALT;
        end else if (w_op10 == OP_ADDI || w_op10 == OP_ANDI || w_op10 == OP_EORI
                     || w_op10 == OP_ORRI || w_op10 == OP_SUBI
                     || w_op10 == OP_SUBIS) begin
            unique case (w_op10)
                OP_ADDI: o_dec.mnem = MN_ADDI;
                OP_ANDI: o_dec.mnem = MN_ANDI;
                OP_EORI: o_dec.mnem = MN_EORI;
                OP_ORRI: o_dec.mnem = MN_ORRI;
                OP_SUBI: o_dec.mnem = MN_SUBI;
                default: o_dec.mnem = MN_SUBIS;
            endcase
            o_dec.rd  = i_word[4:0];
            o_dec.rn  = i_word[9:5];
            o_dec.imm = w_imm12;
        end else if (w_op11 == OP_LDUR || w_op11 == OP_STUR) begin
            o_dec.mnem = (w_op11 == OP_LDUR) ? MN_LDUR : MN_STUR;
            o_dec.rd   = i_word[4:0];
            o_dec.rn   = i_word[9:5];
            o_dec.imm  = w_dimm[ImmW-1:0];
        end else if (w_op6 == OP_B || w_op6 == OP_BL) begin
            o_dec.mnem   = (w_op6 == OP_B) ? MN_B : MN_BL;
            o_dec.tgt    = i_pc + w_boff;
            o_dec.branch = 1'b1;
        end else if (w_op8 == OP_BCOND || w_op8 == OP_CBNZ || w_op8 == OP_CBZ) begin
            unique case (w_op8)
                OP_BCOND: o_dec.mnem = MN_BCOND;
                OP_CBNZ:  o_dec.mnem = MN_CBNZ;
                default:  o_dec.mnem = MN_CBZ;
            endcase
            o_dec.rd     = i_word[4:0];
            o_dec.tgt    = i_pc + w_cboff;
            o_dec.branch = 1'b1;
        end else begin
            o_dec.mnem = MN_UNKN;
        end
    end

endmodule

// File: rtl/core/legv8_decode_with_label_table.sv
// ----------------------------------------------------------------------------
// legv8_decode_with_label_table: LEGv8 decoder with branch-target labels
// Decodes one instruction word, reports the label at its address and
// finds or appends the label of a branch target.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   command  | start, busy, i_instr_word, i_inst_address | in, busy out
//   result   | o_valid, o_mnemonic .. o_table_full       | out
//
// One shared comparator scans the label RAM with an address state and a
// compare state per stored label. A non-branch scans the labels held once
// for its own address, a branch again for its target; a hit ends a scan early.
// busy is high from the cycle after the transfer until the result strobe.
// Reset empties the label table; the RAM itself is not cleared.
// The result is shown for one cycle with o_valid; there is no stall.
// ----------------------------------------------------------------------------
module legv8_decode_with_label_table
    import lgv8dec_pkg::*;
#(
    parameter int unsigned LABEL_ENTRIES = LabelEntriesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [WordW-1:0]    i_instr_word,
    input  logic [WordW-1:0]    i_inst_address,
    output logic                o_valid,
    output logic [4:0]          o_mnemonic,
    output logic [RegW-1:0]     o_reg_d,
    output logic [RegW-1:0]     o_reg_n,
    output logic [RegW-1:0]     o_reg_m,
    output logic [ShW-1:0]      o_shift_amount,
    output logic signed [ImmW-1:0] o_immediate,
    output logic [WordW-1:0]    o_branch_target,
    output logic [LabelW-1:0]   o_target_label,
    output logic                o_label_created,
    output logic [LabelW-1:0]   o_here_label,
    output logic                o_table_full
);

    localparam int unsigned AW = (LABEL_ENTRIES > 1) ? $clog2(LABEL_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(LABEL_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_CMP
    } t_state;

    t_state            r_state;
    logic [WordW-1:0]  r_word;
    logic [WordW-1:0]  r_pc;
    logic              r_pass;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_count;
    logic              r_valid;
    logic [LabelW-1:0] r_here;
    logic [LabelW-1:0] r_tlab;
    logic              r_created;
    logic              r_full;

    t_dec              w_dec;
    logic [WordW-1:0]  w_key;
    logic [WordW-1:0]  w_rdata;
    logic              w_found;
    logic              w_miss;
    logic              w_room;
    logic              w_we;
    logic [CW-1:0]     w_lab_src;
    logic [LabelW-1:0] w_lab;

    lgv8dec_decode u_decode (
        .i_word (r_word),
        .i_pc   (r_pc),
        .o_dec  (w_dec)
    );

    lgv8dec_ram #(
        .WIDTH (WordW),
        .DEPTH (LABEL_ENTRIES)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_dec.tgt),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_key     = r_pass ? w_dec.tgt : r_pc;
    assign w_found   = (r_state == S_CMP) && (w_rdata == w_key);
    assign w_miss    = (r_state == S_ADDR) && (r_idx == r_count);
    assign w_room    = r_count < CW'(LABEL_ENTRIES);
    assign w_we      = w_miss && r_pass && w_room;
    assign w_lab_src = w_found ? CW'(r_idx + 1'b1) : CW'(r_count + 1'b1);

    generate
        if (CW >= LabelW) begin : g_lab_trunc
            assign w_lab = w_lab_src[LabelW-1:0];
        end else begin : g_lab_ext
            assign w_lab = {{(LabelW - CW){1'b0}}, w_lab_src};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_pass    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_word    <= i_instr_word;
                        r_pc      <= i_inst_address;
                        r_pass    <= 1'b0;
                        r_idx     <= '0;
                        r_tlab    <= '0;
                        r_created <= 1'b0;
                        r_full    <= 1'b0;
                        r_state   <= S_ADDR;
                    end
                end
                S_ADDR, S_CMP: begin
                    if (w_found || w_miss) begin
                        if (!r_pass) begin
                            r_here <= w_found ? w_lab : '0;
                            if (w_dec.branch) begin
                                r_pass  <= 1'b1;
                                r_idx   <= '0;
                                r_state <= S_ADDR;
                            end else begin
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            if (w_found) begin
                                r_tlab <= w_lab;
                            end else if (w_room) begin
                                r_tlab    <= w_lab;
                                r_created <= 1'b1;
                                r_count   <= CW'(r_count + 1'b1);
                            end else begin
                                r_full <= 1'b1;
                            end
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (r_state == S_ADDR) begin
                        r_state <= S_CMP;
                    end else begin
                        r_idx   <= CW'(r_idx + 1'b1);
                        r_state <= S_ADDR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_mnemonic       = w_dec.mnem;
    assign o_reg_d          = w_dec.rd;
    assign o_reg_n          = w_dec.rn;
    assign o_reg_m          = w_dec.rm;
    assign o_shift_amount   = w_dec.sh;
    assign o_immediate      = w_dec.imm;
    assign o_branch_target  = w_dec.tgt;
    assign o_target_label   = r_tlab;
    assign o_label_created  = r_created;
    assign o_here_label     = r_here;
    assign o_table_full     = r_full;

`ifndef ASSERT_OFF
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a scan is still running");

    a_created_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_label_created && o_table_full))
        else $error("label created and table full on one result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LABEL_ENTRIES))
        else $error("label count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_label_created) |-> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("label count did not advance with a new label");
`endif

endmodule

// File: dv/tb_legv8_decode_with_label_table.sv
// ----------------------------------------------------------------------------
// tb_legv8_decode_with_label_table: self-checking bench for the LEGv8 decoder
// Drives instruction words and addresses through the start/busy command port.
// An in-bench decoder keeps its own branch-target label table and compares
// every result strobe field by field. A directed pass covers each opcode and
// the corner cases. Random traffic around a small address pool then fills
// the label table, reuses labels and hits the table-full case.
// ----------------------------------------------------------------------------
module tb_legv8_decode_with_label_table;
    import lgv8dec_pkg::*;

    localparam int unsigned LABEL_DEPTH  = LabelEntriesDef;
    localparam int unsigned RANDOM_ITEMS = 1075;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam logic [31:0] POOL_BASE    = 32'h0000_1000;

    typedef struct {
        logic [4:0]  mnem;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [4:0]  rm;
        logic [5:0]  sh;
        logic [11:0] imm;
        logic [31:0] tgt;
        logic [6:0]  tlab;
        logic        created;
        logic [6:0]  here;
        logic        full;
    } t_decode;

    class disasm_scoreboard;
        logic [31:0] label_addr [LABEL_DEPTH];
        int unsigned label_count;
        t_decode     pending [$];
        int          errors;

        function new();
            label_count = 0;
            errors      = 0;
        endfunction

        function int unsigned find_label(logic [31:0] addr);
            for (int unsigned i = 0; i < label_count; i++) begin
                if (label_addr[i] == addr) return i + 1;
            end
            return 0;
        endfunction

        function void note_transfer(logic [31:0] w, logic [31:0] pc);
            t_decode     d;
            logic [10:0] op11;
            logic        hit;
            logic        is_branch;
            int          imm_val;
            int unsigned lab;
            d = '{default: 0};
            op11 = w[31:21];
            is_branch = 1'b0;
            d.here = 7'(find_label(pc));
            hit = 1'b1;
            case (op11)
                OP_ADD:  d.mnem = MN_ADD;
                OP_AND:  d.mnem = MN_AND;
                OP_BR:   d.mnem = MN_BR;
                OP_EOR:  d.mnem = MN_EOR;
                OP_LSL:  d.mnem = MN_LSL;
                OP_LSR:  d.mnem = MN_LSR;
                OP_ORR:  d.mnem = MN_ORR;
                OP_SUB:  d.mnem = MN_SUB;
                OP_SUBS: d.mnem = MN_SUBS;
                OP_MUL:  d.mnem = MN_MUL;
                OP_PRNT: d.mnem = MN_PRNT;
                OP_PRNL: d.mnem = MN_PRNL;
                OP_DUMP: d.mnem = MN_DUMP;
                OP_HALT: d.mnem = MN_HALT;
                default: hit = 1'b0;
            endcase
            if (hit) begin
                if (d.mnem == MN_BR) begin
                    d.rn = w[9:5];
                end else if (d.mnem == MN_LSL || d.mnem == MN_LSR) begin
                    d.rd = w[4:0];
                    d.rn = w[9:5];
                    d.sh = w[15:10];
                end else if (d.mnem == MN_PRNT) begin
                    d.rd = w[4:0];
                end else if (d.mnem < MN_PRNT) begin
                    d.rd = w[4:0];
                    d.rn = w[9:5];
                    d.rm = w[20:16];
                end
            end else begin
                hit = 1'b1;
                case (w[31:22])
                    OP_ADDI:  d.mnem = MN_ADDI;
                    OP_ANDI:  d.mnem = MN_ANDI;
                    OP_EORI:  d.mnem = MN_EORI;
                    OP_ORRI:  d.mnem = MN_ORRI;
                    OP_SUBI:  d.mnem = MN_SUBI;
                    OP_SUBIS: d.mnem = MN_SUBIS;
                    default:  hit = 1'b0;
                endcase
                if (hit) begin
                    d.rd  = w[4:0];
                    d.rn  = w[9:5];
                    d.imm = w[21:10];
                end else if (op11 == OP_LDUR || op11 == OP_STUR) begin
                    d.mnem  = (op11 == OP_LDUR) ? MN_LDUR : MN_STUR;
                    d.rd    = w[4:0];
                    d.rn    = w[9:5];
                    imm_val = $signed(w[21:10]) / 4;
                    d.imm   = imm_val[11:0];
                end else if (w[31:26] == OP_B || w[31:26] == OP_BL) begin
                    d.mnem    = (w[31:26] == OP_B) ? MN_B : MN_BL;
                    d.tgt     = pc + {{4{w[25]}}, w[25:0], 2'b00};
                    is_branch = 1'b1;
                end else if (w[31:24] == OP_BCOND || w[31:24] == OP_CBNZ
                             || w[31:24] == OP_CBZ) begin
                    if (w[31:24] == OP_BCOND)     d.mnem = MN_BCOND;
                    else if (w[31:24] == OP_CBNZ) d.mnem = MN_CBNZ;
                    else                          d.mnem = MN_CBZ;
                    d.rd      = w[4:0];
                    d.tgt     = pc + {{11{w[23]}}, w[23:5], 2'b00};
                    is_branch = 1'b1;
                end else begin
                    d.mnem = MN_UNKN;
                end
            end
            if (is_branch) begin
                lab = find_label(d.tgt);
                if (lab == 0) begin
                    if (label_count < LABEL_DEPTH) begin
                        label_addr[label_count] = d.tgt;
                        label_count++;
                        lab = label_count;
                        d.created = 1'b1;
                    end else begin
                        d.full = 1'b1;
                    end
                end
                d.tlab = lab[6:0];
            end
            pending.push_back(d);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_decode got);
            t_decode want;
            if (pending.size() == 0) begin
                $error("result strobe with no decode pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            cmp_field("mnemonic", want.mnem, got.mnem);
            cmp_field("reg_d", want.rd, got.rd);
            cmp_field("reg_n", want.rn, got.rn);
            cmp_field("reg_m", want.rm, got.rm);
            cmp_field("shift_amount", want.sh, got.sh);
            cmp_field("immediate", want.imm, got.imm);
            cmp_field("branch_target", want.tgt, got.tgt);
            cmp_field("target_label", want.tlab, got.tlab);
            cmp_field("label_created", want.created, got.created);
            cmp_field("here_label", want.here, got.here);
            cmp_field("table_full", want.full, got.full);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [WordW-1:0]     i_instr_word;
    logic [WordW-1:0]     i_inst_address;
    logic                 o_valid;
    logic [4:0]           o_mnemonic;
    logic [RegW-1:0]      o_reg_d;
    logic [RegW-1:0]      o_reg_n;
    logic [RegW-1:0]      o_reg_m;
    logic [ShW-1:0]       o_shift_amount;
    logic signed [ImmW-1:0] o_immediate;
    logic [WordW-1:0]     o_branch_target;
    logic [LabelW-1:0]    o_target_label;
    logic                 o_label_created;
    logic [LabelW-1:0]    o_here_label;
    logic                 o_table_full;

    disasm_scoreboard sb = new();
    int unsigned      stall_cycles = 0;

    legv8_decode_with_label_table DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_instr_word     (i_instr_word),
        .i_inst_address   (i_inst_address),
        .o_valid          (o_valid),
        .o_mnemonic       (o_mnemonic),
        .o_reg_d          (o_reg_d),
        .o_reg_n          (o_reg_n),
        .o_reg_m          (o_reg_m),
        .o_shift_amount   (o_shift_amount),
        .o_immediate      (o_immediate),
        .o_branch_target  (o_branch_target),
        .o_target_label   (o_target_label),
        .o_label_created  (o_label_created),
        .o_here_label     (o_here_label),
        .o_table_full     (o_table_full)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            sb.check_result('{o_mnemonic, o_reg_d, o_reg_n, o_reg_m, o_shift_amount,
                              o_immediate, o_branch_target, o_target_label,
                              o_label_created, o_here_label, o_table_full});
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("legv8_decode_with_label_table verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pool_address();
        return POOL_BASE + 4 * $urandom_range(0, 95);
    endfunction

    function automatic logic [31:0] random_word(logic [31:0] pc, bit near_pool);
        int unsigned kind;
        int          off;
        logic [31:0] r;
        logic [10:0] op11;
        logic [9:0]  op10;
        logic [7:0]  op8;
        kind = $urandom_range(0, 99);
        r    = $urandom();
        off  = $signed(r);
        if (near_pool && $urandom_range(0, 3) != 0) begin
            off = $signed(pool_address() - pc) >>> 2;
        end
        if (kind < 25) begin
            case ($urandom_range(0, 13))
                0:       op11 = OP_ADD;
                1:       op11 = OP_AND;
                2:       op11 = OP_BR;
                3:       op11 = OP_EOR;
                4:       op11 = OP_LSL;
                5:       op11 = OP_LSR;
                6:       op11 = OP_ORR;
                7:       op11 = OP_SUB;
                8:       op11 = OP_SUBS;
                9:       op11 = OP_MUL;
                10:      op11 = OP_PRNT;
                11:      op11 = OP_PRNL;
                12:      op11 = OP_DUMP;
                default: op11 = OP_HALT;
            endcase
            return {op11, r[20:0]};
        end
        if (kind < 38) begin
            case ($urandom_range(0, 5))
                0:       op10 = OP_ADDI;
                1:       op10 = OP_ANDI;
                2:       op10 = OP_EORI;
                3:       op10 = OP_ORRI;
                4:       op10 = OP_SUBI;
                default: op10 = OP_SUBIS;
            endcase
            return {op10, r[21:0]};
        end
        if (kind < 48) return {($urandom_range(0, 1) ? OP_LDUR : OP_STUR), r[20:0]};
        if (kind < 63) return {($urandom_range(0, 1) ? OP_B : OP_BL), off[25:0]};
        if (kind < 80) begin
            case ($urandom_range(0, 2))
                0:       op8 = OP_BCOND;
                1:       op8 = OP_CBNZ;
                default: op8 = OP_CBZ;
            endcase
            return {op8, off[18:0], r[4:0]};
        end
        return r;
    endfunction

    task automatic send_item(input logic [31:0] w, input logic [31:0] pc);
        start          <= 1'b1;
        i_instr_word   <= w;
        i_inst_address <= pc;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_transfer(w, pc);
    endtask

    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    initial begin
        logic [31:0] pc;
        bit          near_pool;
        int unsigned idle_pct;
        int unsigned pick;
        start          = 1'b0;
        i_instr_word   = '0;
        i_inst_address = '0;
        i_rst_n        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item({OP_B, 26'h2000000}, 32'h0000_0000);
        send_item({OP_BL, 26'h0000001}, 32'hFFFF_FFFC);
        send_item({OP_BCOND, 19'h00000, 5'd31}, POOL_BASE);
        send_item({OP_CBZ, 19'h7FFFC, 5'd0}, POOL_BASE + 32'h10);
        send_item({OP_CBNZ, 19'h3FFFF, 5'd31}, 32'h0000_2000);
        send_item({OP_ADD, 21'h1FFFFF}, POOL_BASE);
        send_item({OP_AND, 21'h000000}, 32'h0000_0000);
        send_item({OP_BR, 5'd7, 6'd5, 5'd9, 5'd3}, POOL_BASE + 32'h4);
        send_item({OP_EOR, 21'h15A5A5}, POOL_BASE + 32'h8);
        send_item({OP_LSL, 5'd21, 6'd63, 5'd10, 5'd5}, POOL_BASE + 32'hC);
        send_item({OP_LSR, 5'd0, 6'd1, 5'd31, 5'd31}, 32'h8000_0000);
        send_item({OP_ORR, 21'h0A5A5A}, 32'h7FFF_FFFC);
        send_item({OP_SUB, 21'h123456}, 32'h0000_0004);
        send_item({OP_SUBS, 21'h1EDCBA}, 32'h0000_0008);
        send_item({OP_MUL, 21'h1FFFFF}, 32'h0000_000C);
        send_item({OP_PRNT, 21'h1FFFFF}, 32'h0000_0010);
        send_item({OP_PRNL, 21'h1FFFFF}, 32'h0000_0014);
        send_item({OP_DUMP, 21'h1FFFFF}, 32'h0000_0018);
        send_item(32'hFFFF_FFFF, 32'hF800_0000);
        send_item({OP_ADDI, 12'h7FF, 5'd1, 5'd2}, 32'h0000_0020);
        send_item({OP_ANDI, 12'h800, 5'd31, 5'd31}, 32'h0000_0024);
        send_item({OP_EORI, 12'h000, 5'd0, 5'd0}, 32'h0000_0028);
        send_item({OP_ORRI, 12'hFFF, 5'd17, 5'd4}, 32'h0000_002C);
        send_item({OP_SUBI, 12'h123, 5'd8, 5'd16}, 32'h0000_0030);
        send_item({OP_SUBIS, 12'hEDC, 5'd30, 5'd1}, 32'h0000_0034);
        send_item({OP_LDUR, 11'h7FF, 5'd31, 5'd31}, 32'h0000_0038);
        send_item({OP_STUR, 11'h003, 5'd2, 5'd9}, 32'h0000_003C);
        send_item(32'h0000_0000, 32'hFFFF_FFF0);
        wait_drained();

        idle_pct = 0;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            end
            if (n >= RANDOM_ITEMS - 150) idle_pct = 0;
            if (n == RANDOM_ITEMS / 2) wait_drained();
            if ($urandom_range(1, 100) <= idle_pct) hold_off($urandom_range(1, 9));
            pick = $urandom_range(0, 9);
            near_pool = (pick < 7);
            if (pick < 7)       pc = pool_address();
            else if (pick < 8)  pc = 32'hFFFF_FF00 + 4 * $urandom_range(0, 63);
            else                pc = $urandom();
            send_item(random_word(pc, near_pool), pc);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("legv8_decode_with_label_table verification clean");
        end else begin
            $display("legv8_decode_with_label_table verification failed");
        end
        $finish;
    end

endmodule

// File: legv8_decode_with_label_table.f
rtl/core/lgv8dec_pkg.sv
rtl/core/lgv8dec_ram.sv
rtl/core/lgv8dec_decode.sv
rtl/core/legv8_decode_with_label_table.sv
dv/tb_legv8_decode_with_label_table.sv
